>>> src/bcpi_pkg.sv
// bcpi_pkg: widths, request payload types, controller states and commands
// for the bicubic patch interpolator; depends on nothing else
package bcpi_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  // column results carry eight guard bits over a sample
  localparam int COL_BITS    = SAMPLE_BITS + 8;
  // horner terms of a column-result cubic stay within these bits
  localparam int CALC_BITS   = COL_BITS + 6;
  // term times an unsigned fraction with a zero sign bit
  localparam int PROD_BITS   = CALC_BITS + FRAC_BITS + 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_row0;
    logic signed [SAMPLE_BITS-1:0] sample_row1;
    logic signed [SAMPLE_BITS-1:0] sample_row2;
    logic signed [SAMPLE_BITS-1:0] sample_row3;
    logic [FRAC_BITS-1:0]          frac_v;
    logic [FRAC_BITS-1:0]          frac_u;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] interp_value;
    logic                          saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_COL_DONE,
    ST_ROW_OUT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       prep;
    logic       mul_a;
    logic       mul_b;
    logic       mul_c;
    logic       store_col;
    logic [1:0] store_idx;
    logic       load_row;
    logic       write_out;
  } dp_cmd_t;

endpackage

>>> src/bcpi_ctrl.sv
// bcpi_ctrl: sequencer for the column and row cubic passes and the output
// request valid; depends on bcpi_pkg
module bcpi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bcpi_pkg::dp_cmd_t cmd
);
  import bcpi_pkg::*;

  state_t     state, state_next;
  logic [1:0] column_count, column_count_next;
  logic       row_pass, row_pass_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next        = state;
    column_count_next = column_count;
    row_pass_next     = row_pass;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PREP;
      end
      ST_PREP:  state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_MUL_C;
      ST_MUL_C: state_next = row_pass ? ST_ROW_OUT : ST_COL_DONE;
      ST_COL_DONE: begin
        if (column_count == 2'd3) begin
          row_pass_next = 1'b1;
          state_next    = ST_PREP;
        end else begin
          column_count_next = column_count + 2'd1;
          state_next        = ST_IDLE;
        end
      end
      ST_ROW_OUT: begin
        if (out_free) begin
          row_pass_next     = 1'b0;
          column_count_next = 2'd0;
          state_next        = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.store_idx = column_count;
    in_ready      = (state == ST_IDLE);
    case (state)
      ST_IDLE:     cmd.load_in = in_valid;
      ST_PREP:     cmd.prep = 1'b1;
      ST_MUL_A:    cmd.mul_a = 1'b1;
      ST_MUL_B:    cmd.mul_b = 1'b1;
      ST_MUL_C:    cmd.mul_c = 1'b1;
      ST_COL_DONE: begin
        cmd.store_col = (column_count != 2'd3);
        cmd.load_row  = (column_count == 2'd3);
      end
      ST_ROW_OUT:  cmd.write_out = out_free;
      default:     cmd = '0;
    endcase
  end

  // output request valid
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.write_out) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= 2'd0;
      row_pass     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      column_count <= column_count_next;
      row_pass     <= row_pass_next;
      out_valid    <= out_valid_next;
    end
  end

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |-> (!out_valid || out_ready))
    else $error("result written over a pending output request");

  // the row pass only runs once four columns are held
  a_row_full: assert property (@(posedge clk) disable iff (rst)
    row_pass |-> (column_count == 2'd3))
    else $error("row pass started without four columns");

  // an accepted column starts its cubic on the next cycle
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_PREP && !row_pass))
    else $error("accepted column did not start a column pass");

  // the row result goes out with the count cleared
  a_out_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |=> (column_count == 2'd0 && out_valid))
    else $error("row result left column count set");

endmodule

>>> src/bcpi_datapath.sv
// bcpi_datapath: operand registers, horner cubic on one shared multiplier,
// column result store and output register; depends on bcpi_pkg
module bcpi_datapath (
  input  logic                 clk,
  input  bcpi_pkg::in_item_t   in_item,
  input  bcpi_pkg::dp_cmd_t    cmd,
  output bcpi_pkg::out_item_t  out_item
);
  import bcpi_pkg::*;

  localparam logic signed [CALC_BITS-1:0] COL_MAX =
    {{(CALC_BITS-COL_BITS+1){1'b0}}, {(COL_BITS-1){1'b1}}};
  localparam logic signed [CALC_BITS-1:0] COL_MIN = ~COL_MAX;
  localparam logic signed [CALC_BITS-1:0] SMP_MAX =
    {{(CALC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [CALC_BITS-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic signed [PROD_BITS-1:0] HALF_F =
    PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_BITS-1:0] HALF_F2 =
    PROD_BITS'(1) << FRAC_BITS;

  logic signed [COL_BITS-1:0]  p [4];
  logic [FRAC_BITS-1:0]        f;
  logic [FRAC_BITS-1:0]        fu;
  logic signed [CALC_BITS-1:0] a, b, c, s, r;
  logic signed [COL_BITS-1:0]  column_results [3];

  logic signed [CALC_BITS-1:0] e0, e1, e2, e3, d12;
  logic signed [CALC_BITS-1:0] a_next, b_next, c_next;
  logic signed [CALC_BITS-1:0] mul_op;
  logic signed [FRAC_BITS:0]   f_s;
  logic signed [PROD_BITS-1:0] prod, rnd_f, rnd_f2;
  logic signed [COL_BITS-1:0]  col_clip;
  logic signed [SAMPLE_BITS-1:0] val_clip;
  logic                        val_hit;

  // cubic coefficients from the four operands
  always_comb begin
    e0      = CALC_BITS'(p[0]);
    e1      = CALC_BITS'(p[1]);
    e2      = CALC_BITS'(p[2]);
    e3      = CALC_BITS'(p[3]);
    d12     = e1 - e2;
    a_next  = (d12 <<< 1) + d12 + e3 - e0;
    b_next  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c_next  = e2 - e0;
  end

  // shared multiplier, round half up by fraction or twice the fraction
  always_comb begin
    mul_op = cmd.mul_a ? a : s;
    f_s    = $signed({1'b0, f});
    prod   = PROD_BITS'(mul_op) * PROD_BITS'(f_s);
    rnd_f  = (prod + HALF_F) >>> FRAC_BITS;
    rnd_f2 = (prod + HALF_F2) >>> (FRAC_BITS + 1);
  end

  // saturation of the column result and of the final value
  always_comb begin
    if (r > COL_MAX)      col_clip = COL_MAX[COL_BITS-1:0];
    else if (r < COL_MIN) col_clip = COL_MIN[COL_BITS-1:0];
    else                  col_clip = r[COL_BITS-1:0];
    val_hit = 1'b1;
    if (r > SMP_MAX)      val_clip = SMP_MAX[SAMPLE_BITS-1:0];
    else if (r < SMP_MIN) val_clip = SMP_MIN[SAMPLE_BITS-1:0];
    else begin
      val_clip = r[SAMPLE_BITS-1:0];
      val_hit  = 1'b0;
    end
  end

  // operand loading, horner steps and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      p[0] <= COL_BITS'(in_item.sample_row0);
      p[1] <= COL_BITS'(in_item.sample_row1);
      p[2] <= COL_BITS'(in_item.sample_row2);
      p[3] <= COL_BITS'(in_item.sample_row3);
      f    <= in_item.frac_v;
      fu   <= in_item.frac_u;
    end
    if (cmd.load_row) begin
      p[0] <= column_results[0];
      p[1] <= column_results[1];
      p[2] <= column_results[2];
      p[3] <= col_clip;
      f    <= fu;
    end
    if (cmd.prep) begin
      a <= a_next;
      b <= b_next;
      c <= c_next;
    end
    if (cmd.mul_a) s <= b + CALC_BITS'(rnd_f);
    if (cmd.mul_b) s <= c + CALC_BITS'(rnd_f);
    if (cmd.mul_c) r <= CALC_BITS'(p[1]) + CALC_BITS'(rnd_f2);
    if (cmd.store_col) column_results[cmd.store_idx] <= col_clip;
    if (cmd.write_out) begin
      out_item.interp_value <= val_clip;
      out_item.saturated    <= val_hit;
    end
  end

endmodule

>>> src/bicubic_patch_interpolator.sv
// bicubic_patch_interpolator: top level joining the sequencer and the
// datapath; depends on bcpi_pkg, bcpi_ctrl and bcpi_datapath
//
//   channel  | direction | handshake            | payload
//   in       | request in  | in_valid / in_ready  | in_item  (one patch column)
//   out      | request out | out_valid / out_ready| out_item (one per patch)
//
// no new column is accepted until the last one is through its cubic; the
// fourth column also runs the row cubic before the next ready. the single
// multiplier steps the three horner terms of each cubic in turn.
// reset clears the sequencer, the column count and the output valid.
// a waiting result holds the row pass in its last state until it is taken.
module bicubic_patch_interpolator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bcpi_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bcpi_pkg::out_item_t out_item
);
  import bcpi_pkg::*;

  dp_cmd_t cmd;

  bcpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bcpi_datapath u_datapath (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .out_item (out_item)
  );

endmodule
